### src/zpmf_pkg.sv
// zpmf_pkg: shared constants, codes and types of the zero-padded median filter
// used by every module under src but zpmf_ram; depends on nothing

package zpmf_pkg;

  // defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_MASK_DEF  = 5;

  // fixed field widths, sized for the whole parameter range
  localparam int COL_W      = 12;
  localparam int ROW_W      = 13;
  localparam int BANK_W     = 3;
  localparam int CW_W       = 11;
  localparam int CH_W       = 13;
  localparam int CM_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int PIX_W      = 8;
  localparam int QUEUE_DEPTH = 4;

  // register reset values
  localparam logic [CW_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [CH_W-1:0] HEIGHT_RST = 13'd1024;
  localparam logic [CM_W-1:0] MASK_RST   = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MASK   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // effective (clamped) frame settings
  typedef struct packed {
    logic [CW_W-1:0] w;
    logic [CH_W-1:0] h;
    logic [CM_W-1:0] ms;
  } cfg_t;

  // one classified item from front to back
  typedef struct packed {
    logic              wr;
    logic [BANK_W-1:0] wr_bank;
    logic [COL_W-1:0]  wr_col;
    logic [PIX_W-1:0]  pixel;
    logic              emit;
    logic              last;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic [BANK_W-1:0] out_bank;
  } cmd_t;

endpackage

### src/zpmf_ram.sv
// zpmf_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module zpmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/zpmf_front.sv
// zpmf_front: configuration registers, input/output position counters and item
// classification; depends on zpmf_pkg

module zpmf_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_MASK  = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [zpmf_pkg::PIX_W-1:0]      s_tdata,
  input  logic                            s_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [zpmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zpmf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            q_full,
  output logic                            q_push,
  output zpmf_pkg::cmd_t                  q_cmd,
  output zpmf_pkg::cfg_t                  cfg
);
  import zpmf_pkg::*;

  localparam int LINES  = MAX_MASK + 1;
  localparam int WCLAMP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;

  logic [CW_W-1:0]   width_r;
  logic [CH_W-1:0]   height_r;
  logic [CM_W-1:0]   mask_r;
  logic [ROW_W-1:0]  in_row, in_row_next, out_row, out_row_next;
  logic [COL_W-1:0]  in_col, in_col_next, out_col, out_col_next;
  logic [BANK_W-1:0] in_bank, in_bank_next, out_bank, out_bank_next;

  logic [CW_W-1:0]   w;
  logic [CH_W-1:0]   h;
  logic [CM_W-1:0]   ms, up, down;
  logic [COL_W-1:0]  w_col, wm1, in_col_inc, need_c;
  logic [ROW_W-1:0]  hm1, need_r, in_row1;
  logic [ROW_W:0]    need_r_w;
  logic [COL_W-1:0]  in_col1;
  logic [BANK_W-1:0] in_bank1;
  logic              acc, wr, full1, ready, last;

  // clamp register values to the legal range
  always_comb begin
    if (width_r == '0) w = CW_W'(1);
    else if (width_r > CW_W'(WCLAMP)) w = CW_W'(WCLAMP);
    else w = width_r;
    h = (height_r == '0) ? CH_W'(1) : height_r;
    if (mask_r == '0) ms = CM_W'(1);
    else if (mask_r > CM_W'(MAX_MASK)) ms = CM_W'(MAX_MASK);
    else ms = mask_r;
    up   = ms >> 1;
    down = ms - CM_W'(1) - up;
  end

  assign cfg = '{w: w, h: h, ms: ms};

  // a register write takes the cycle, input waits
  assign s_tready  = !q_full && !cfg_valid;
  assign cfg_ready = 1'b1;
  assign acc       = s_tvalid && s_tready;

  // input side: store the pixel and advance the input position
  always_comb begin
    w_col      = {{(COL_W-CW_W){1'b0}}, w};
    wm1        = w_col - COL_W'(1);
    hm1        = h - ROW_W'(1);
    wr         = (op_t'(s_tuser) == OP_PIXEL) && (in_row < h);
    in_col_inc = in_col + COL_W'(1);
    in_col1    = in_col;
    in_row1    = in_row;
    in_bank1   = in_bank;
    if (wr) begin
      if (in_col_inc >= w_col) begin
        in_col1  = '0;
        in_row1  = in_row + ROW_W'(1);
        in_bank1 = (in_bank == BANK_W'(LINES-1)) ? '0 : in_bank + BANK_W'(1);
      end else begin
        in_col1 = in_col_inc;
      end
    end
    full1 = in_row1 >= h;
  end

  // output side: emit once the lower-right pixel of the window is in
  always_comb begin
    need_r_w = {1'b0, out_row} + {{(ROW_W+1-CM_W){1'b0}}, down};
    need_r   = (need_r_w > {1'b0, hm1}) ? hm1 : need_r_w[ROW_W-1:0];
    need_c = out_col + {{(COL_W-CM_W){1'b0}}, down};
    if (need_c > wm1) need_c = wm1;
    ready = full1 || (in_row1 > need_r) || ((in_row1 == need_r) && (in_col1 > need_c));
    last  = (out_row == hm1) && (out_col == wm1);

    in_row_next   = in_row1;
    in_col_next   = in_col1;
    in_bank_next  = in_bank1;
    out_row_next  = out_row;
    out_col_next  = out_col;
    out_bank_next = out_bank;
    if (ready) begin
      if (last) begin
        in_row_next   = '0;
        in_col_next   = '0;
        in_bank_next  = '0;
        out_row_next  = '0;
        out_col_next  = '0;
        out_bank_next = '0;
      end else if (out_col + COL_W'(1) >= w_col) begin
        out_col_next  = '0;
        out_row_next  = out_row + ROW_W'(1);
        out_bank_next = (out_bank == BANK_W'(LINES-1)) ? '0 : out_bank + BANK_W'(1);
      end else begin
        out_col_next = out_col + COL_W'(1);
      end
    end
  end

  // classified beat for the back end
  assign q_push = acc;
  assign q_cmd  = '{wr: wr, wr_bank: in_bank, wr_col: in_col, pixel: s_tdata,
                    emit: ready, last: last, out_row: out_row, out_col: out_col,
                    out_bank: out_bank};

  // register writes restart the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      mask_r   <= MASK_RST;
      in_row   <= '0;
      in_col   <= '0;
      in_bank  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_bank <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH: begin
          width_r <= cfg_data[CW_W-1:0];
        end
        CFG_HEIGHT: begin
          height_r <= cfg_data[CH_W-1:0];
        end
        CFG_MASK: begin
          mask_r <= cfg_data[CM_W-1:0];
        end
        default: begin
        end
      endcase
      if (cfg_idx_t'(cfg_index) == CFG_WIDTH || cfg_idx_t'(cfg_index) == CFG_HEIGHT ||
          cfg_idx_t'(cfg_index) == CFG_MASK) begin
        in_row   <= '0;
        in_col   <= '0;
        in_bank  <= '0;
        out_row  <= '0;
        out_col  <= '0;
        out_bank <= '0;
      end
    end else if (acc) begin
      in_row   <= in_row_next;
      in_col   <= in_col_next;
      in_bank  <= in_bank_next;
      out_row  <= out_row_next;
      out_col  <= out_col_next;
      out_bank <= out_bank_next;
    end
  end

endmodule

### src/zpmf_queue.sv
// zpmf_queue: short command queue between front and back end
// depends on zpmf_pkg

module zpmf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  zpmf_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output zpmf_pkg::cmd_t head
);
  import zpmf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          slots [0:QUEUE_DEPTH-1];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  assign full     = count == (PW+1)'(QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign head     = slots[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PW'(1);
      if (pop) rptr <= rptr + PW'(1);
      if (push && !pop) count <= count + (PW+1)'(1);
      else if (pop && !push) count <= count - (PW+1)'(1);
    end
  end

endmodule

### src/zpmf_sort.sv
// zpmf_sort: pipelined odd-even transposition sorting network with median pick
// and output register; depends on zpmf_pkg

module zpmf_sort #(
  parameter int N  = 25,
  parameter int IW = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [zpmf_pkg::PIX_W-1:0] in_vals [0:N-1],
  input  logic [IW-1:0]              in_idx,
  input  logic                       in_last,
  output logic                       adv,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [zpmf_pkg::PIX_W-1:0] m_tdata,
  output logic                       m_tlast
);
  import zpmf_pkg::*;

  logic [PIX_W-1:0] sv   [0:N][0:N-1];
  logic             sval [0:N];
  logic [IW-1:0]    sidx [0:N];
  logic             slast[0:N];

  // whole pipeline moves when the output register can take a beat
  assign adv = !m_tvalid || m_tready;

  // stage 0 loads the window
  always_ff @(posedge clk) begin
    if (rst) begin
      sval[0] <= 1'b0;
    end else if (adv) begin
      sval[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sv[0]    <= in_vals;
      sidx[0]  <= in_idx;
      slast[0] <= in_last;
    end
  end

  // one compare-exchange pass per stage, alternating pair parity
  for (genvar s = 0; s < N; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        sval[s+1] <= 1'b0;
      end else if (adv) begin
        sval[s+1] <= sval[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sidx[s+1]  <= sidx[s];
        slast[s+1] <= slast[s];
      end
    end

    for (genvar e = 0; e < N; e++) begin : g_elem
      if ((e % 2) == (s % 2) && (e + 1) < N) begin : g_lo
        always_ff @(posedge clk) begin
          if (adv) begin
            sv[s+1][e] <= (sv[s][e] < sv[s][e+1]) ? sv[s][e] : sv[s][e+1];
          end
        end
      end else if (e > 0 && ((e - 1) % 2) == (s % 2)) begin : g_hi
        always_ff @(posedge clk) begin
          if (adv) begin
            sv[s+1][e] <= (sv[s][e-1] < sv[s][e]) ? sv[s][e] : sv[s][e-1];
          end
        end
      end else begin : g_pass
        always_ff @(posedge clk) begin
          if (adv) begin
            sv[s+1][e] <= sv[s][e];
          end
        end
      end
    end
  end

  // output register with median pick
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= sval[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= sv[N][sidx[N]];
      m_tlast <= slast[N];
    end
  end

endmodule

### src/zpmf_back.sv
// zpmf_back: line store banks, column fetch with row-start preload, sliding window
// and the sorting network; depends on zpmf_pkg, zpmf_ram, zpmf_sort

module zpmf_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_MASK  = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  zpmf_pkg::cfg_t             cfg,
  input  logic                       q_valid,
  input  zpmf_pkg::cmd_t             q_head,
  output logic                       q_pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [zpmf_pkg::PIX_W-1:0] m_tdata,
  output logic                       m_tlast
);
  import zpmf_pkg::*;

  localparam int LINES = MAX_MASK + 1;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int N     = MAX_MASK * MAX_MASK;
  localparam int IW    = $clog2(N);

  logic              adv, issue, need_pre, first, do_wr, clear, fin;
  logic [CM_W-1:0]   up, down, pre_cnt;
  logic [COL_W:0]    col_rd;
  logic              col_ok;
  logic [BANK_W:0]   base;
  logic [BANK_W-1:0] bank_dr [0:MAX_MASK-1];
  logic              row_ok  [0:MAX_MASK-1];
  logic              byp     [0:MAX_MASK-1];
  logic [PIX_W-1:0]  rdata   [0:LINES-1];
  logic [ROW_W:0]    row_t   [0:MAX_MASK-1];
  logic [5:0]        msq;

  // read stage registers
  logic              r1_valid, r1_final, r1_clear, r1_col_ok, r1_last;
  logic [BANK_W-1:0] r1_bank [0:MAX_MASK-1];
  logic              r1_rok  [0:MAX_MASK-1];
  logic              r1_byp  [0:MAX_MASK-1];
  logic [PIX_W-1:0]  r1_pix;
  logic [CM_W-1:0]   r1_ms;
  logic [IW-1:0]     r1_idx;

  logic [PIX_W-1:0]  win      [0:MAX_MASK-1][0:MAX_MASK-1];
  logic [PIX_W-1:0]  win_next [0:MAX_MASK-1][0:MAX_MASK-1];
  logic [PIX_W-1:0]  colv     [0:MAX_MASK-1];
  logic [PIX_W-1:0]  sort_in  [0:N-1];

  assign up   = cfg.ms >> 1;
  assign down = cfg.ms - CM_W'(1) - up;
  assign msq  = {3'b000, cfg.ms} * {3'b000, cfg.ms};

  // issue: preload left columns at a row start, then the new right column
  always_comb begin
    issue    = adv && q_valid;
    need_pre = q_head.emit && (q_head.out_col == '0) && (pre_cnt < down);
    first    = pre_cnt == '0;
    do_wr    = q_head.wr && first;
    clear    = q_head.emit && (q_head.out_col == '0) && first;
    fin      = !need_pre;
    if (need_pre) col_rd = {{(COL_W+1-CM_W){1'b0}}, pre_cnt};
    else col_rd = {1'b0, q_head.out_col} + {{(COL_W+1-CM_W){1'b0}}, down};
    col_ok = col_rd < {{(COL_W+1-CW_W){1'b0}}, cfg.w};
    q_pop  = issue && !need_pre;
  end

  // bank and padding of each window row
  always_comb begin
    base = {1'b0, q_head.out_bank} + (BANK_W+1)'(LINES) - {1'b0, up[BANK_W-1:0]};
    if (base >= (BANK_W+1)'(LINES)) base = base - (BANK_W+1)'(LINES);
    for (int d = 0; d < MAX_MASK; d++) begin
      logic [BANK_W:0] b;
      b = base + (BANK_W+1)'(d);
      if (b >= (BANK_W+1)'(LINES)) b = b - (BANK_W+1)'(LINES);
      bank_dr[d] = b[BANK_W-1:0];
      row_t[d]   = {1'b0, q_head.out_row} + (ROW_W+1)'(d);
      row_ok[d]  = (row_t[d] >= {{(ROW_W+1-CM_W){1'b0}}, up}) &&
                   ((row_t[d] - {{(ROW_W+1-CM_W){1'b0}}, up}) <
                    {{(ROW_W+1-CH_W){1'b0}}, cfg.h});
      byp[d]     = do_wr && (q_head.wr_bank == bank_dr[d]) &&
                   ({1'b0, q_head.wr_col} == col_rd);
    end
  end

  // line store, one bank per buffered row
  for (genvar b = 0; b < LINES; b++) begin : g_bank
    zpmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (issue && do_wr && (q_head.wr_bank == BANK_W'(b))),
      .waddr (q_head.wr_col[AW-1:0]),
      .wdata (q_head.pixel),
      .re    (adv),
      .raddr (col_rd[AW-1:0]),
      .rdata (rdata[b])
    );
  end

  // preload counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_cnt <= '0;
    end else if (issue) begin
      pre_cnt <= need_pre ? pre_cnt + CM_W'(1) : '0;
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (adv) begin
      r1_valid <= issue && q_head.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_final  <= fin;
      r1_clear  <= clear;
      r1_col_ok <= col_ok;
      r1_last   <= q_head.last;
      r1_pix    <= q_head.pixel;
      r1_ms     <= cfg.ms;
      r1_idx    <= IW'(msq >> 1);
      for (int d = 0; d < MAX_MASK; d++) begin
        r1_bank[d] <= bank_dr[d];
        r1_rok[d]  <= row_ok[d];
        r1_byp[d]  <= byp[d];
      end
    end
  end

  // new column enters at the right, window slides left
  always_comb begin
    for (int d = 0; d < MAX_MASK; d++) begin
      if (!r1_rok[d] || !r1_col_ok) colv[d] = '0;
      else if (r1_byp[d]) colv[d] = r1_pix;
      else colv[d] = rdata[r1_bank[d]];
      for (int c = 0; c < MAX_MASK - 1; c++) begin
        win_next[d][c] = r1_clear ? '0 : win[d][c+1];
      end
      win_next[d][MAX_MASK-1] = colv[d];
    end
    // active window is the upper-right mask_size square, rest pads high
    for (int d = 0; d < MAX_MASK; d++) begin
      for (int c = 0; c < MAX_MASK; c++) begin
        if ((CM_W'(d) < r1_ms) && (CM_W'(c) >= CM_W'(MAX_MASK) - r1_ms))
          sort_in[d*MAX_MASK+c] = win_next[d][c];
        else
          sort_in[d*MAX_MASK+c] = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && r1_valid) begin
      win <= win_next;
    end
  end

  zpmf_sort #(.N(N), .IW(IW)) u_sort (
    .clk      (clk),
    .rst      (rst),
    .in_valid (r1_valid && r1_final),
    .in_vals  (sort_in),
    .in_idx   (r1_idx),
    .in_last  (r1_last),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### src/zero_padded_median_filter.sv
// zero_padded_median_filter: top level of the streaming 2-d median filter
// depends on zpmf_pkg, zpmf_front, zpmf_queue, zpmf_back
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  tdata = pixel, tuser = opcode
//   m_*      out        m_tvalid/m_tready  tdata = median_pixel, tlast = last_of_frame
//   cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one beat per cycle in and one median per cycle out while no stall holds them; every output
// row starts with preload reads of its down = mask_size-1-mask_size/2 left columns
// a median passes the command queue, the read stage registers, the fixed-depth
// transposition sorting network and its output register
// reset is synchronous; the line store needs no clearing pass
// output stalls back up through the sort pipeline into the command queue;
// input also waits in a cycle with a register write

module zero_padded_median_filter
  import zpmf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_MASK  = MAX_MASK_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
  input  logic                  s_tuser,   // [0] opcode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [PIX_W-1:0]      m_tdata,   // [7:0] median_pixel
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t q_cmd, q_head;
  cfg_t cfg;
  logic q_push, q_full, q_pop, q_valid;

  zpmf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_MASK(MAX_MASK)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .cfg       (cfg)
  );

  zpmf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .din      (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_valid),
    .head     (q_head)
  );

  zpmf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_MASK(MAX_MASK)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### src/zpmf_checker.sv
// zpmf_checker: port-level assertions for the median filter top level
// depends on zpmf_pkg; bound to zero_padded_median_filter

module zpmf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [zpmf_pkg::PIX_W-1:0]     m_tdata,
  input logic                           m_tlast,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // no result right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // empty queue takes input right after reset unless a register write is pending
  a_rst_in: assert property (@(posedge clk) rst |=> s_tready || cfg_valid)
    else $error("input not ready after reset");

  // config port never stalls
  a_cfg_rdy: assert property (@(posedge clk) !rst |-> cfg_ready)
    else $error("config port stalled");

endmodule

bind zero_padded_median_filter zpmf_checker u_chk (.*);

### tb/sv/zero_padded_median_filter_tb.sv
// zero_padded_median_filter_tb: self-checking testbench of the zero-padded median filter
// depends on zpmf_pkg and zero_padded_median_filter; predicts every median beat in-line
`timescale 1ns / 100ps

module zero_padded_median_filter_tb;
  import zpmf_pkg::*;

  localparam int MAXW  = 1024;
  localparam int MAXM  = 5;
  localparam int LINES = MAXM + 1;
  localparam int LIMIT = 600000;

  typedef struct {
    logic [7:0] median;
    logic       last;
  } median_beat_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [PIX_W-1:0]      m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  zero_padded_median_filter dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model state of the filter
  logic [7:0]  lines_mem [LINES][MAXW];
  logic [10:0] reg_width;
  logic [12:0] reg_height;
  logic [2:0]  reg_mask;
  int          pin_row, pin_col, pout_row, pout_col;
  bit          frame_closed;

  median_beat_t pending_medians[$];
  int  tx_idle, rx_idle;
  int  mismatches, items_sent, medians_seen, frames_run, cycles;

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_tready <= ($urandom % 100) >= rx_idle;
  end

  // compare each median beat with the oldest prediction
  always @(posedge clk) begin
    median_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      medians_seen <= medians_seen + 1;
      if (pending_medians.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected beat: median %0d last %0d", m_tdata, m_tlast);
      end else begin
        want = pending_medians.pop_front();
        if (want.median !== m_tdata || want.last !== m_tlast) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected median %0d last %0d, got median %0d last %0d",
                     want.median, want.last, m_tdata, m_tlast);
        end
      end
    end
  end

  function automatic int eff_w();
    if (reg_width == 0) return 1;
    if (reg_width > MAXW) return MAXW;
    return int'(reg_width);
  endfunction

  function automatic int eff_h();
    return (reg_height == 0) ? 1 : int'(reg_height);
  endfunction

  function automatic int eff_m();
    if (reg_mask == 0) return 1;
    if (reg_mask > MAXM) return MAXM;
    return int'(reg_mask);
  endfunction

  function automatic void restart_positions();
    pin_row = 0; pin_col = 0; pout_row = 0; pout_col = 0;
  endfunction

  // sorted-window median at the current output position
  function automatic logic [7:0] window_median(int w, int h, int ms);
    logic [7:0] win [MAXM*MAXM];
    logic [7:0] key;
    int n, rr, cc, j;
    n = 0;
    for (int dr = 0; dr < ms; dr++)
      for (int dc = 0; dc < ms; dc++) begin
        rr = pout_row - ms / 2 + dr;
        cc = pout_col - ms / 2 + dc;
        win[n] = (rr >= 0 && rr < h && cc >= 0 && cc < w) ? lines_mem[rr % LINES][cc] : 8'd0;
        n++;
      end
    for (int i = 1; i < n; i++) begin
      key = win[i];
      j = i - 1;
      while (j >= 0 && win[j] > key) begin
        win[j + 1] = win[j];
        j--;
      end
      win[j + 1] = key;
    end
    return win[n / 2];
  endfunction

  // advance the model by one accepted beat, queue any median it causes
  function automatic void predict_median(op_t op, logic [7:0] pix);
    int w, h, ms, down, need_r, need_c;
    bit full, last;
    median_beat_t b;
    w = eff_w(); h = eff_h(); ms = eff_m();
    down = ms - 1 - ms / 2;
    if (pin_col >= w) pin_col = w - 1;
    if (pout_col >= w) pout_col = w - 1;
    full = pin_row >= h;
    if (op == OP_PIXEL && !full) begin
      lines_mem[pin_row % LINES][pin_col] = pix;
      pin_col++;
      if (pin_col >= w) begin
        pin_col = 0;
        pin_row++;
      end
      full = pin_row >= h;
    end
    if (pout_row >= h) begin
      restart_positions();
      return;
    end
    need_r = (pout_row + down > h - 1) ? h - 1 : pout_row + down;
    need_c = (pout_col + down > w - 1) ? w - 1 : pout_col + down;
    if (!full && !(pin_row > need_r || (pin_row == need_r && pin_col > need_c))) return;
    b.median = window_median(w, h, ms);
    last = (pout_row == h - 1 && pout_col == w - 1);
    b.last = last;
    pending_medians.push_back(b);
    if (last) begin
      restart_positions();
      frame_closed = 1'b1;
    end else begin
      pout_col++;
      if (pout_col >= w) begin
        pout_col = 0;
        pout_row++;
      end
    end
  endfunction

  // one beat on the stream input, with random idle gaps before it
  task automatic send_beat(op_t op, logic [7:0] pix);
    if (($urandom % 100) < tx_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    predict_median(op, pix);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIDTH:  reg_width  = val[10:0];
      CFG_HEIGHT: reg_height = val;
      default:    reg_mask   = val[2:0];
    endcase
    restart_positions();
    frame_closed = 1'b0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for all predicted medians, then for the sort pipeline to empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_medians.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  function automatic logic [7:0] pattern_pixel(int mode, int k);
    case (mode)
      1: return 8'hFF;
      2: return 8'h00;
      3: return (k % 2) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // configure, stream a frame with optional drain noise, then drain it out unless cut short
  task automatic run_frame(int w, int h, int m, int mode, int noise, int cut);
    int npix;
    settle();
    write_reg(CFG_WIDTH, 13'(w));
    write_reg(CFG_HEIGHT, 13'(h));
    write_reg(CFG_MASK, 13'(m));
    frames_run++;
    npix = eff_w() * eff_h();
    if (cut > 0 && cut < npix) npix = cut;
    for (int k = 0; k < npix; k++) begin
      if (($urandom % 100) < noise) send_beat(OP_DRAIN, 8'($urandom_range(0, 255)));
      send_beat(OP_PIXEL, pattern_pixel(mode, k));
    end
    // pixels beyond a full frame act as drains
    while (cut == 0 && !frame_closed)
      send_beat((($urandom % 100) < 30) ? OP_PIXEL : OP_DRAIN, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    tx_idle = 26; rx_idle = 56;
    run_frame(1, 1, 1, 1, 0, 0);
    run_frame(1, 1, 5, 2, 0, 0);
    run_frame(0, 0, 0, 3, 0, 0);
    run_frame(3, 3, 3, 3, 0, 0);
    run_frame(2, 2, 7, 1, 30, 0);
    run_frame(2, 1, 6, 0, 30, 0);
  endtask

  task automatic test_extremes();
    run_frame(2047, 1, 5, 0, 0, 60);
    run_frame(1, 4095, 2, 0, 0, 60);
    run_frame(1024, 2, 4, 3, 0, 60);
    run_frame(5, 8191, 3, 0, 0, 12);
  endtask

  task automatic test_restart_midframe();
    run_frame(6, 5, 5, 0, 10, 13);
    run_frame(6, 5, 5, 0, 10, 0);
  endtask

  task automatic test_random(int txp, int rxp, int budget);
    int start;
    tx_idle = txp; rx_idle = rxp;
    start = items_sent;
    while (items_sent - start < budget)
      run_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 7),
                ($urandom % 8 == 0) ? $urandom_range(1, 3) : 0, $urandom_range(0, 15),
                ($urandom % 10 == 0) ? $urandom_range(1, 20) : 0);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
    m_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_WIDTH; cfg_data = '0;
    tx_idle = 0; rx_idle = 0;
    mismatches = 0; items_sent = 0; medians_seen = 0; frames_run = 0; cycles = 0;
    reg_width = WIDTH_RST; reg_height = HEIGHT_RST; reg_mask = MASK_RST;
    frame_closed = 1'b0;
    restart_positions();
    for (int r = 0; r < LINES; r++)
      for (int c = 0; c < MAXW; c++) lines_mem[r][c] = 8'd0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_extremes();
    test_restart_midframe();
    test_random(26, 56, 240);
    test_random(56, 26, 240);
    test_random(0, 0, 240);
    settle();

    if (pending_medians.size() != 0) mismatches++;
    $display("covered %0d frames, %0d input beats, %0d median beats checked",
             frames_run, items_sent, medians_seen);
    $display("widths up to the clamp, heights up to 8191, masks 0..7, restarts and drain noise");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
src/zpmf_pkg.sv
src/zpmf_ram.sv
src/zpmf_front.sv
src/zpmf_queue.sv
src/zpmf_sort.sv
src/zpmf_back.sv
src/zero_padded_median_filter.sv
src/zpmf_checker.sv
tb/sv/zero_padded_median_filter_tb.sv
